// ===== rtl/core/jafsg_pkg.sv =====
// ----------------------------------------------------------------------------
// jafsg_pkg: shared types and constants for the joystick axis filter
// Fixed-point weights, register codes, reset values and the records that
// move between the front, the command queue and the send gate.
// ----------------------------------------------------------------------------
package jafsg_pkg;

  // Q16 filter weights, 0.7 and 0.3 (they sum to 65536)
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [15:0] W_OLD     = 16'd45875;
  localparam logic [14:0] W_NEW     = 15'd19661;

  localparam int unsigned DZ_W   = 11;
  localparam int unsigned IVL_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned TIME_W = 32;

  localparam logic [DZ_W-1:0]  DEADZONE_RST = 11'd180;
  localparam logic [IVL_W-1:0] INTERVAL_RST = 16'd30;

  // output mapping: floor(i * 200 / full) - 100
  localparam logic [7:0] MAP_SPAN   = 8'd200;
  localparam logic [7:0] MAP_OFFSET = 8'd100;

  typedef enum logic {
    CFG_DEADZONE = 1'b0,
    CFG_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DZ_W-1:0]  deadzone;
    logic [IVL_W-1:0] interval;
  } cfg_t;

  // mapped command leaving the front
  typedef struct packed {
    logic signed [CMD_W-1:0] thr;
    logic signed [CMD_W-1:0] ste;
    logic                    fire;
    logic [TIME_W-1:0]       now;
  } cmd_t;

  // packet emitted by the send gate
  typedef struct packed {
    logic signed [CMD_W-1:0] thr;
    logic signed [CMD_W-1:0] ste;
    logic                    fire;
  } pkt_t;

endpackage

// ===== rtl/core/jafsg_fifo.sv =====
// ----------------------------------------------------------------------------
// jafsg_fifo: small register queue
// First-word fall-through queue; DEPTH must be a power of two, at least 2.
// ----------------------------------------------------------------------------
module jafsg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             we, re;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign we      = push_i && !full_o;
  assign re      = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = we ? AW'(wptr_q + 1'b1) : wptr_q;
    rptr_d = re ? AW'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q;
    if (we && !re) begin
      cnt_d = NW'(cnt_q + 1'b1);
    end else if (re && !we) begin
      cnt_d = NW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/jafsg_front.sv =====
// ----------------------------------------------------------------------------
// jafsg_front: filter and mapping pipeline
// Four stages: sample weighting, filter update, centre/deadzone/scale,
// divide by full scale. Never stalls; the top keeps it within queue credit.
// ----------------------------------------------------------------------------
module jafsg_front #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS-1:0] steer_i,
  input  logic [SAMPLE_BITS-1:0] thr_i,
  input  logic                   fire_i,
  input  logic [31:0]            now_i,
  input  jafsg_pkg::cfg_t        cfg_i,
  output logic                   cmd_valid_o,
  output jafsg_pkg::cmd_t        cmd_o
);

  localparam int unsigned FB = jafsg_pkg::FRAC_BITS;
  localparam int unsigned SW = SAMPLE_BITS + FB;       // filter state
  localparam int unsigned PW = SAMPLE_BITS + 15;       // sample * W_NEW
  localparam int unsigned AW = SW + 16;                // filter accumulator
  localparam int unsigned XW = SAMPLE_BITS + 8;        // i * 200
  localparam int unsigned YW = XW + 1;
  localparam int unsigned QW = 9;                      // quotient estimate
  localparam int unsigned CW = (SAMPLE_BITS > jafsg_pkg::DZ_W) ?
                               SAMPLE_BITS + 1 : jafsg_pkg::DZ_W + 1;
  localparam logic [SAMPLE_BITS-1:0] CENTER = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [YW-1:0] FULL = YW'({SAMPLE_BITS{1'b1}});

  function automatic logic [SW-1:0] smooth(input logic [SW-1:0] old,
                                           input logic [PW-1:0] p);
    logic [AW-1:0] acc;
    acc = AW'(old) * AW'(jafsg_pkg::W_OLD) + (AW'(p) << FB);
    return acc[AW-1:FB];
  endfunction

  function automatic logic in_dz(input logic [SAMPLE_BITS-1:0] ip,
                                 input logic [jafsg_pkg::DZ_W-1:0] dz);
    logic [SAMPLE_BITS-1:0] mag;
    mag = (ip >= CENTER) ? SAMPLE_BITS'(ip - CENTER) : SAMPLE_BITS'(CENTER - ip);
    return (CW'(mag) < CW'(dz));
  endfunction

  // x / (2^n - 1) ~= (x + x>>n) >> n, low by at most one
  function automatic logic [QW-1:0] q_est(input logic [XW-1:0] x);
    logic [YW-1:0] s;
    s = YW'(x) + YW'(x >> SAMPLE_BITS);
    return QW'(s >> SAMPLE_BITS);
  endfunction

  function automatic logic [7:0] map_out(input logic [QW-1:0] q0,
                                         input logic [XW-1:0] x,
                                         input logic          zero);
    logic [YW-1:0] qd, r;
    logic [QW-1:0] q;
    qd = (YW'(q0) << SAMPLE_BITS) - YW'(q0);
    r  = YW'(x) - qd;
    q  = (r >= FULL) ? QW'(q0 + 1'b1) : q0;
    return zero ? 8'd0 : 8'(8'(q) - jafsg_pkg::MAP_OFFSET);
  endfunction

  // stage 1
  logic            v1_q, fire1_q;
  logic [31:0]     now1_q;
  logic [PW-1:0]   pste_q, pthr_q;
  // stage 2
  logic            v2_q, fire2_q;
  logic [31:0]     now2_q;
  logic [SW-1:0]   ste_st_q, thr_st_q;
  // stage 3
  logic            v3_q, fire3_q, zste3_q, zthr3_q;
  logic [31:0]     now3_q;
  logic [XW-1:0]   xste3_q, xthr3_q;
  // stage 4
  logic            v4_q, fire4_q, zste4_q, zthr4_q;
  logic [31:0]     now4_q;
  logic [XW-1:0]   xste4_q, xthr4_q;
  logic [QW-1:0]   qste4_q, qthr4_q;

  logic [SAMPLE_BITS-1:0] ste_ip, thr_ip;

  assign ste_ip = ste_st_q[SW-1:FB];
  assign thr_ip = thr_st_q[SW-1:FB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      ste_st_q <= '0;
      thr_st_q <= '0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (v1_q) begin
        ste_st_q <= smooth(ste_st_q, pste_q);
        thr_st_q <= smooth(thr_st_q, pthr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pste_q  <= PW'(steer_i) * PW'(jafsg_pkg::W_NEW);
      pthr_q  <= PW'(thr_i) * PW'(jafsg_pkg::W_NEW);
      fire1_q <= fire_i;
      now1_q  <= now_i;
    end
    if (v1_q) begin
      fire2_q <= fire1_q;
      now2_q  <= now1_q;
    end
    if (v2_q) begin
      fire3_q <= fire2_q;
      now3_q  <= now2_q;
      zste3_q <= in_dz(ste_ip, cfg_i.deadzone);
      zthr3_q <= in_dz(thr_ip, cfg_i.deadzone);
      xste3_q <= XW'(ste_ip) * XW'(jafsg_pkg::MAP_SPAN);
      xthr3_q <= XW'(thr_ip) * XW'(jafsg_pkg::MAP_SPAN);
    end
    if (v3_q) begin
      fire4_q <= fire3_q;
      now4_q  <= now3_q;
      zste4_q <= zste3_q;
      zthr4_q <= zthr3_q;
      xste4_q <= xste3_q;
      xthr4_q <= xthr3_q;
      qste4_q <= q_est(xste3_q);
      qthr4_q <= q_est(xthr3_q);
    end
  end

  assign cmd_valid_o = v4_q;
  assign cmd_o.thr   = map_out(qthr4_q, xthr4_q, zthr4_q);
  assign cmd_o.ste   = map_out(qste4_q, xste4_q, zste4_q);
  assign cmd_o.fire  = fire4_q;
  assign cmd_o.now   = now4_q;

endmodule

// ===== rtl/core/jafsg_gate.sv =====
// ----------------------------------------------------------------------------
// jafsg_gate: send gate
// Emits a packet when it differs from the last one sent and the send
// interval has elapsed; keeps the last packet and its timestamp.
// ----------------------------------------------------------------------------
module jafsg_gate (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  jafsg_pkg::cmd_t cmd_i,
  input  jafsg_pkg::cfg_t cfg_i,
  input  logic            out_full_i,
  output logic            cmd_pop_o,
  output logic            pkt_push_o,
  output jafsg_pkg::pkt_t pkt_o
);

  jafsg_pkg::pkt_t   sent_q;
  logic [31:0]       last_q;
  logic [31:0]       elapsed;
  logic              differ, pass;

  assign pkt_o.thr  = cmd_i.thr;
  assign pkt_o.ste  = cmd_i.ste;
  assign pkt_o.fire = cmd_i.fire;

  assign elapsed    = 32'(cmd_i.now - last_q);
  assign differ     = (pkt_o != sent_q);
  assign pass       = differ && (elapsed >= 32'(cfg_i.interval));
  assign cmd_pop_o  = cmd_valid_i && !out_full_i;
  assign pkt_push_o = cmd_pop_o && pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
      last_q <= '0;
    end else if (pkt_push_o) begin
      sent_q <= pkt_o;
      last_q <= cmd_i.now;
    end
  end

endmodule

// ===== rtl/core/joystick_axis_filter_and_send_gate_top.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_filter_and_send_gate_top: two-axis joystick filter and gate
// Smooths steering and throttle, applies a deadzone, maps to -100..100 and
// forwards a packet only when it changed and the send interval has passed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the samples, fire level and now_ms with push high;
//   a transfer happens on a clock edge with push high and full low.
//   Result channel: while empty is low the oldest packet sits on
//   throttle_out_o / steering_out_o / fire_out_o; pop high transfers it.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 deadzone,
//   1 send interval) in that cycle; write only while the block is idle.
// Timing:
//   One item per cycle sustained while full stays low. A packet caused by an
//   item passes four front stages (weighting, filter update, deadzone/scale,
//   divide) and the command queue, then the send gate writes the result
//   queue, whose head drives the result ports.
//   Items that are not sent leave no result.
// Reset:
//   Filter states, last packet and last send time clear to zero; deadzone
//   returns to 180 and the interval to 30 ms. Queues come up empty.
// Stall:
//   When the receiver stops popping, the result queue fills, the gate holds,
//   and the command queue absorbs the front; full rises once MID_DEPTH items
//   are outstanding between the input and the gate.
// ----------------------------------------------------------------------------
module joystick_axis_filter_and_send_gate_top #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned MID_DEPTH   = 8,
  parameter int unsigned OUT_DEPTH   = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input channel
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] steer_sample_i,
  input  logic [SAMPLE_BITS-1:0] throttle_sample_i,
  input  logic                   fire_pressed_i,
  input  logic [31:0]            now_ms_i,
  // result channel
  output logic                   empty,
  input  logic                   pop,
  output logic signed [7:0]      throttle_out_o,
  output logic signed [7:0]      steering_out_o,
  output logic                   fire_out_o,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MID_DEPTH + 1);

  jafsg_pkg::cfg_t cfg_q;
  jafsg_pkg::cmd_t front_cmd, mid_cmd;
  jafsg_pkg::pkt_t gate_pkt, out_pkt;

  logic             accept;
  logic             front_valid;
  logic             mid_empty, mid_full, mid_pop;
  logic             pkt_push, out_full;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone <= jafsg_pkg::DEADZONE_RST;
      cfg_q.interval <= jafsg_pkg::INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (jafsg_pkg::cfg_idx_e'(cfg_idx_i))
        jafsg_pkg::CFG_DEADZONE: begin
          cfg_q.deadzone <= cfg_data_i[jafsg_pkg::DZ_W-1:0];
        end
        jafsg_pkg::CFG_INTERVAL: begin
          cfg_q.interval <= cfg_data_i[jafsg_pkg::IVL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Credit: items from input transfer until the gate takes them from the
  // command queue. The front cannot stall, so this keeps the queue safe.
  assign accept = push && !full;
  assign full   = (cnt_q == CNT_W'(MID_DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !mid_pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (mid_pop && !accept) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  jafsg_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .steer_i     (steer_sample_i),
    .thr_i       (throttle_sample_i),
    .fire_i      (fire_pressed_i),
    .now_i       (now_ms_i),
    .cfg_i       (cfg_q),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  // decouples the front from the gate
  jafsg_fifo #(
    .WIDTH ($bits(jafsg_pkg::cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_cmd),
    .pop_i   (mid_pop),
    .rdata_o (mid_cmd),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  jafsg_gate u_gate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!mid_empty),
    .cmd_i       (mid_cmd),
    .cfg_i       (cfg_q),
    .out_full_i  (out_full),
    .cmd_pop_o   (mid_pop),
    .pkt_push_o  (pkt_push),
    .pkt_o       (gate_pkt)
  );

  // result queue; its head drives the result ports
  jafsg_fifo #(
    .WIDTH ($bits(jafsg_pkg::pkt_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pkt_push),
    .wdata_i (gate_pkt),
    .pop_i   (pop),
    .rdata_o (out_pkt),
    .empty_o (empty),
    .full_o  (out_full)
  );

  assign throttle_out_o = out_pkt.thr;
  assign steering_out_o = out_pkt.ste;
  assign fire_out_o     = out_pkt.fire;

  // credit count stays within the command queue
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MID_DEPTH))
    else $error("credit count above command queue depth");

  // front never writes a full command queue
  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(front_valid && mid_full))
    else $error("command queue overflow");

  // gate never writes a full result queue
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pkt_push && out_full))
    else $error("result queue overflow");

  // an input transfer with no gate take adds one credit
  a_credit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !mid_pop) |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
    else $error("credit count did not advance");

  // mapped commands stay within -100..100
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (($signed(throttle_out_o) >= -8'sd100) &&
                ($signed(throttle_out_o) <= 8'sd100) &&
                ($signed(steering_out_o) >= -8'sd100) &&
                ($signed(steering_out_o) <= 8'sd100)))
    else $error("mapped command out of range");

endmodule

// ===== sim/joystick_axis_filter_and_send_gate_top_tb.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_filter_and_send_gate_top_tb: self-checking bench for the gate
// Drives steering/throttle samples, fire level and timestamps through the
// input channel and keeps its own copy of both axis filters, the deadzone and
// scale stage and the send gate. Each popped packet is checked field by field
// against the oldest predicted packet. Both sides idle at random. There is a
// long receiver hold-off and there are drain pauses between register phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_axis_filter_and_send_gate_top_tb;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned SETTLE_CYC  = 10;   // slack waited after the last predicted packet
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned HOLD_CYC    = 80;
  localparam int unsigned IDLE_PCT    = 13;

  // ---------------------------------------------------------------------------
  // DUT signals: every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   push              = 1'b0;
  logic                   full;
  logic [SAMPLE_BITS-1:0] steer_sample_i    = '0;
  logic [SAMPLE_BITS-1:0] throttle_sample_i = '0;
  logic                   fire_pressed_i    = 1'b0;
  logic [31:0]            now_ms_i          = '0;
  logic                   empty;
  logic                   pop               = 1'b0;
  logic signed [7:0]      throttle_out_o;
  logic signed [7:0]      steering_out_o;
  logic                   fire_out_o;
  logic                   cfg_we_i          = 1'b0;
  logic [0:0]             cfg_idx_i         = '0;
  logic [15:0]            cfg_data_i        = '0;

  joystick_axis_filter_and_send_gate_top #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .steer_sample_i,
    .throttle_sample_i,
    .fire_pressed_i,
    .now_ms_i,
    .empty,
    .pop,
    .throttle_out_o,
    .steering_out_o,
    .fire_out_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // ---------------------------------------------------------------------------
  // Predictor state, mirrors the block's reset values
  // ---------------------------------------------------------------------------
  logic [27:0]                 steer_state    = '0;
  logic [27:0]                 throttle_state = '0;
  jafsg_pkg::pkt_t             last_pkt       = '0;
  logic [31:0]                 last_sent_ms   = '0;
  logic [jafsg_pkg::DZ_W-1:0]  dz_cfg         = jafsg_pkg::DEADZONE_RST;
  logic [jafsg_pkg::IVL_W-1:0] ivl_cfg        = jafsg_pkg::INTERVAL_RST;

  jafsg_pkg::pkt_t expected_pkts[$];
  int              error_count = 0;

  // calm: no idling on either side; hold_req: receiver hold-off request
  bit calm     = 1'b0;
  int hold_req = 0;
  int hold_left = 0;

  // ---------------------------------------------------------------------------
  // Clock, reset and the run limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  // one filter update: 0.7 * old + 0.3 * sample in 12.16, truncated
  function automatic logic [27:0] filter_update(logic [27:0] old, logic [11:0] s);
    logic [63:0] acc;
    acc = 64'(old) * 64'(jafsg_pkg::W_OLD) +
          ((64'(s) * 64'(jafsg_pkg::W_NEW)) << jafsg_pkg::FRAC_BITS);
    return 28'(acc >> jafsg_pkg::FRAC_BITS);
  endfunction

  // integer part centred at 2048, deadzone, clamp, scale to -100..100
  function automatic logic signed [7:0] axis_command(logic [27:0] st);
    int diff;
    int mag;
    diff = int'(st[27:16]) - 2048;
    mag  = (diff < 0) ? -diff : diff;
    if (mag < int'(dz_cfg)) return 8'sd0;
    if (diff < -2048) diff = -2048;
    if (diff > 2047) diff = 2047;
    return 8'(((diff + 2048) * 200) / 4095 - 100);
  endfunction

  // advance the model by one accepted item, queue a packet if the gate opens
  task automatic predict_item(input logic [11:0] steer, input logic [11:0] thr,
                              input logic fire, input logic [31:0] now);
    jafsg_pkg::pkt_t cand;
    logic [31:0]     elapsed;
    steer_state    = filter_update(steer_state, steer);
    throttle_state = filter_update(throttle_state, thr);
    cand.thr  = axis_command(throttle_state);
    cand.ste  = axis_command(steer_state);
    cand.fire = fire;
    elapsed   = now - last_sent_ms;   // wraps modulo 2^32
    if (cand != last_pkt && elapsed >= 32'(ivl_cfg)) begin
      last_pkt     = cand;
      last_sent_ms = now;
      expected_pkts.push_back(cand);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: optional random gap, then hold push until the transfer.
  // push stays high into the next item when there is no gap.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [11:0] steer, input logic [11:0] thr,
                           input logic fire, input logic [31:0] now);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push              <= 1'b1;
    steer_sample_i    <= steer;
    throttle_sample_i <= thr;
    fire_pressed_i    <= fire;
    now_ms_i          <= now;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_item(steer, thr, fire, now);
  endtask

  // stop sending and wait for every predicted packet plus pipeline slack;
  // items that produce no packet may still be in flight
  task automatic settle_block();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (expected_pkts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_register(input jafsg_pkg::cfg_idx_e idx,
                                input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      jafsg_pkg::CFG_DEADZONE: dz_cfg = value[jafsg_pkg::DZ_W-1:0];
      jafsg_pkg::CFG_INTERVAL: ivl_cfg = value[jafsg_pkg::IVL_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and packet check. pop idles at random, or is held low for a
  // counted stretch when a test asks for it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    jafsg_pkg::pkt_t want;
    if (pop && !empty) begin
      if (expected_pkts.size() == 0) begin
        $error("packet with none predicted: thr %0d ste %0d fire %0b",
               throttle_out_o, steering_out_o, fire_out_o);
        error_count++;
      end else begin
        want = expected_pkts.pop_front();
        if (throttle_out_o !== want.thr) begin
          $error("throttle_out: expected %0d, actual %0d", want.thr, throttle_out_o);
          error_count++;
        end
        if (steering_out_o !== want.ste) begin
          $error("steering_out: expected %0d, actual %0d", want.ste, steering_out_o);
          error_count++;
        end
        if (fire_out_o !== want.fire) begin
          $error("fire_out: expected %0b, actual %0b", want.fire, fire_out_o);
          error_count++;
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // after reset the last packet is all zero: a zero packet must not go out
  // until something else has; wide deadzone forces both axes to zero
  task automatic test_zero_packet_after_reset();
    write_register(jafsg_pkg::CFG_DEADZONE, 16'd2047);
    for (int i = 1; i <= 4; i++) send_item(12'd2048, 12'd2048, 1'b0, 32'(i * 100));
    send_item(12'd2048, 12'd2048, 1'b1, 32'd500);
  endtask

  // full-scale samples, no deadzone, no interval
  task automatic test_sample_extremes();
    settle_block();
    write_register(jafsg_pkg::CFG_DEADZONE, 16'd0);
    write_register(jafsg_pkg::CFG_INTERVAL, 16'd0);
    send_item(12'd4095, 12'd0,    1'b1, last_sent_ms + 32'd1);
    send_item(12'd0,    12'd4095, 1'b0, last_sent_ms + 32'd1);
    send_item(12'd4095, 12'd4095, 1'b1, last_sent_ms + 32'd1);
    send_item(12'd0,    12'd0,    1'b0, last_sent_ms + 32'd1);
    send_item(12'd4095, 12'd0,    1'b0, last_sent_ms + 32'd1);
    send_item(12'd2048, 12'd2047, 1'b1, last_sent_ms + 32'd1);
  endtask

  // interval just missed and just met, widest interval, timer wrap;
  // fire is the opposite of the last sent packet's so the packet always differs
  task automatic test_interval_gate();
    settle_block();
    write_register(jafsg_pkg::CFG_DEADZONE, 16'(jafsg_pkg::DEADZONE_RST));
    write_register(jafsg_pkg::CFG_INTERVAL, 16'd30);
    send_item(12'd1000, 12'd3000, ~last_pkt.fire, last_sent_ms + 32'd500);
    send_item(12'd1000, 12'd3000, ~last_pkt.fire, last_sent_ms + 32'd29);
    send_item(12'd1000, 12'd3000, ~last_pkt.fire, last_sent_ms + 32'd30);
    settle_block();
    write_register(jafsg_pkg::CFG_INTERVAL, 16'hFFFF);
    send_item(12'd3000, 12'd1000, ~last_pkt.fire, last_sent_ms + 32'd65534);
    send_item(12'd3000, 12'd1000, ~last_pkt.fire, last_sent_ms + 32'd65535);
    settle_block();
    write_register(jafsg_pkg::CFG_INTERVAL, 16'd30);
    send_item(12'd2048, 12'd2048, ~last_pkt.fire, 32'hFFFF_FFF0);
    send_item(12'd2048, 12'd2048, ~last_pkt.fire, 32'h0000_000D);  // 29 after wrap
    send_item(12'd2048, 12'd2048, ~last_pkt.fire, 32'h0000_000E);  // 30 after wrap
  endtask

  // receiver stalls while every item makes a packet: result queue and
  // command queue fill and full must hold off the sender
  task automatic test_backpressure();
    logic [31:0] t;
    settle_block();
    write_register(jafsg_pkg::CFG_INTERVAL, 16'd0);
    calm     = 1'b1;
    hold_req = HOLD_CYC;
    t        = $urandom;
    for (int i = 0; i < 40; i++) begin
      t = t + 32'($urandom_range(0, 5));
      send_item(12'($urandom), 12'($urandom), ~last_pkt.fire, t);
    end
    settle_block();
    calm = 1'b0;
  endtask

  // stick-like streams: held targets with jitter, rising time, occasional
  // fire changes; some pure noise items mixed in
  task automatic test_random_streams();
    int          steer_tgt;
    int          thr_tgt;
    int          s;
    int          h;
    logic        fire;
    logic [31:0] clock_ms;
    logic [15:0] dz;
    logic [15:0] ivl;
    for (int phase = 0; phase < 10; phase++) begin
      settle_block();
      case ($urandom_range(0, 3))
        0: dz = 16'd0;
        1: dz = 16'd2047;
        2: dz = 16'(jafsg_pkg::DEADZONE_RST);
        default: dz = 16'($urandom_range(0, 2047));
      endcase
      case ($urandom_range(0, 3))
        0: ivl = 16'd0;
        1: ivl = 16'hFFFF;
        2: ivl = 16'(jafsg_pkg::INTERVAL_RST);
        default: ivl = 16'($urandom_range(0, 100));
      endcase
      // make sure both extremes of each register are visited
      if (phase == 0) begin
        dz  = 16'd0;
        ivl = 16'd0;
      end else if (phase == 1) begin
        dz  = 16'd2047;
        ivl = 16'hFFFF;
      end
      write_register(jafsg_pkg::CFG_DEADZONE, dz);
      write_register(jafsg_pkg::CFG_INTERVAL, ivl);
      calm      = (phase == 3);
      clock_ms  = $urandom;
      steer_tgt = $urandom_range(0, 4095);
      thr_tgt   = $urandom_range(0, 4095);
      fire      = 1'b0;
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_item(12'($urandom), 12'($urandom), 1'($urandom), $urandom);
        end else begin
          if ($urandom_range(0, 99) < 15) steer_tgt = $urandom_range(0, 4095);
          if ($urandom_range(0, 99) < 15) thr_tgt = $urandom_range(0, 4095);
          if ($urandom_range(0, 99) < 10) fire = ~fire;
          s = steer_tgt + int'($urandom_range(0, 16)) - 8;
          h = thr_tgt + int'($urandom_range(0, 16)) - 8;
          s = (s < 0) ? 0 : (s > 4095) ? 4095 : s;
          h = (h < 0) ? 0 : (h > 4095) ? 4095 : h;
          clock_ms = clock_ms + 32'($urandom_range(0, 2 * int'(ivl) + 4));
          send_item(12'(s), 12'(h), fire, clock_ms);
        end
      end
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence and verdict
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    test_zero_packet_after_reset();
    test_sample_extremes();
    test_interval_gate();
    test_backpressure();
    test_random_streams();
    settle_block();
    if (expected_pkts.size() != 0) begin
      $error("%0d predicted packets never popped", expected_pkts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
